FILE: design/fsbm_pkg.sv
// Shared types, constants and register codes for the fixed-string byte matcher.
package fsbm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_EOF  = 1'b1;

   localparam logic KIND_MATCH    = 1'b0;
   localparam logic KIND_NO_MATCH = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic        report_kind;
      logic [31:0] match_offset;
      logic [31:0] line_number;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [63:0] data;
   } csr_payload_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: design/fsbm_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface fsbm_chan_if #(
   parameter type PAYLOAD_TYPE = logic
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/fixed_string_byte_matcher_core.sv
// Top level of the fixed-string byte matcher: channels, counters and control.
// Reports: a match or no-match report is loaded into the report register, which drives the
//   response channel. A new item is taken only once the last one has left its compare step;
//   the accept cycle shifts the cell row, then the compare step checks it against the pattern.
// A waiting report stalls the compare cycle only if a second report is ready.
// Reset: pattern length 1, pattern bytes zero, window zero, counters cleared, line 1.
module fixed_string_byte_matcher_core #(
   parameter int MAX_PATTERN = fsbm_pkg::MAX_PATTERN_DEFAULT,
   parameter int COUNT_WIDTH = fsbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   fsbm_chan_if.sink   req_chan,
   fsbm_chan_if.source rsp_chan,
   fsbm_chan_if.sink   csr_chan
);
   localparam int FILL_W = $clog2(MAX_PATTERN + 1);
   localparam int LEN_W  = (FILL_W > 5) ? FILL_W : 5;

   // Configuration registers
   logic [4:0]  pattern_length_ff, pattern_length_in;
   logic [63:0] pattern_low_ff, pattern_low_in;
   logic [63:0] pattern_high_ff, pattern_high_in;

   // Per-file state
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0] start_count_ff, start_count_in;
   logic [COUNT_WIDTH-1:0] line_count_ff, line_count_in;
   logic                   matched_ff, matched_in;

   // Compare stage control
   logic busy_ff, busy_in;
   logic eof_ff, eof_in;
   logic check_ff, check_in;

   // Report register
   logic                      rsp_valid_ff, rsp_valid_in;
   fsbm_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   fsbm_pkg::req_payload_type   req;
   fsbm_pkg::csr_payload_type   csr;
   fsbm_pkg::cell_ctrl_type     cell_ctrl;
   logic [MAX_PATTERN-1:0][7:0] pattern_bytes;
   logic [LEN_W-1:0]            len_raw;
   logic [LEN_W-1:0]            active_len;
   logic [FILL_W-1:0]           fill_next;
   logic                        hit_all;
   logic                        accept;
   logic                        has_result;
   logic                        finish;
   logic                        csr_write;

   assign req       = req_chan.payload;
   assign csr       = csr_chan.payload;
   assign accept    = req_chan.valid && req_chan.ready;
   assign csr_write = csr_chan.valid && csr_chan.ready;

   // Take one item at a time; a finished report may still be waiting downstream.
   assign req_chan.ready   = !busy_ff;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Unpack the pattern; bytes beyond sixteen read as zero.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
      if (k < 8) begin : g_low
         assign pattern_bytes[k] = pattern_low_ff[8*k +: 8];
      end else if (k < 16) begin : g_high
         assign pattern_bytes[k] = pattern_high_ff[8*(k-8) +: 8];
      end else begin : g_zero
         assign pattern_bytes[k] = 8'h00;
      end
   end

   // Length zero acts as one, length above the cell count acts as the cell count.
   assign len_raw = LEN_W'(pattern_length_ff);
   always_comb begin
      active_len = len_raw;
      if (len_raw == '0) begin
         active_len = LEN_W'(1);
      end else if (len_raw > LEN_W'(MAX_PATTERN)) begin
         active_len = LEN_W'(MAX_PATTERN);
      end
   end

   assign fill_next = (fill_ff == FILL_W'(MAX_PATTERN)) ? fill_ff : fill_ff + FILL_W'(1);

   // Report: no-match at end of file without a match, match when the row agrees.
   assign has_result = eof_ff ? !matched_ff : (check_ff && hit_all);
   assign finish     = busy_ff && (!has_result || !rsp_valid_ff || rsp_chan.ready);

   fsbm_chain #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_chain (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (cell_ctrl),
      .byte_in       (req.data_byte),
      .pattern_bytes (pattern_bytes),
      .active_len    (active_len),
      .hit_all       (hit_all)
   );

   always_comb begin
      pattern_length_in = pattern_length_ff;
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      fill_in           = fill_ff;
      start_count_in    = start_count_ff;
      line_count_in     = line_count_ff;
      matched_in        = matched_ff;
      busy_in           = busy_ff;
      eof_in            = eof_ff;
      check_in          = check_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in       = rsp_data_ff;
      cell_ctrl         = '0;

      // Configuration writes; indexes past the list are dropped.
      if (csr_write) begin
         case (csr.index)
            fsbm_pkg::REG_PATTERN_LENGTH: pattern_length_in = csr.data[4:0];
            fsbm_pkg::REG_PATTERN_LOW:    pattern_low_in    = csr.data;
            fsbm_pkg::REG_PATTERN_HIGH:   pattern_high_in   = csr.data;
            default:                      ;
         endcase
      end

      // Accept: shift the row and advance counters for a data byte.
      if (accept) begin
         busy_in  = 1'b1;
         eof_in   = (req.func == fsbm_pkg::FUNC_EOF);
         check_in = 1'b0;
         if (req.func == fsbm_pkg::FUNC_DATA) begin
            cell_ctrl.shift = 1'b1;
            fill_in         = fill_next;
            if (req.data_byte == fsbm_pkg::NEWLINE_BYTE && line_count_ff != '1) begin
               line_count_in = line_count_ff + COUNT_WIDTH'(1);
            end
            if (LEN_W'(fill_next) >= active_len) begin
               check_in = 1'b1;
               if (start_count_ff != '1) begin
                  start_count_in = start_count_ff + COUNT_WIDTH'(1);
               end
            end
         end
      end

      // Compare stage: load the report, then clear per-file state at end of file.
      if (finish) begin
         busy_in = 1'b0;
         if (has_result) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.line_number = 32'(line_count_ff);
            if (eof_ff) begin
               rsp_data_in.report_kind  = fsbm_pkg::KIND_NO_MATCH;
               rsp_data_in.match_offset = 32'd0;
            end else begin
               rsp_data_in.report_kind  = fsbm_pkg::KIND_MATCH;
               rsp_data_in.match_offset = 32'(start_count_ff);
            end
         end
         if (eof_ff) begin
            cell_ctrl.clear = 1'b1;
            fill_in         = '0;
            start_count_in  = '0;
            line_count_in   = COUNT_WIDTH'(1);
            matched_in      = 1'b0;
         end else if (has_result) begin
            matched_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= 5'd1;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         fill_ff           <= '0;
         start_count_ff    <= '0;
         line_count_ff     <= COUNT_WIDTH'(1);
         matched_ff        <= 1'b0;
         busy_ff           <= 1'b0;
         eof_ff            <= 1'b0;
         check_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         fill_ff           <= fill_in;
         start_count_ff    <= start_count_in;
         line_count_ff     <= line_count_in;
         matched_ff        <= matched_in;
         busy_ff           <= busy_in;
         eof_ff            <= eof_in;
         check_ff          <= check_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Hold the report payload; no reset needed.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end
endmodule

FILE: design/fsbm_cell.sv
// One window cell: holds a byte, passes it on, compares it to its pattern byte.
module fsbm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  fsbm_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             byte_in,
   input  logic [7:0]             pattern_byte,
   input  logic                   active,
   output logic [7:0]             byte_out,
   output logic                   hit
);
   logic [7:0] byte_ff;
   logic [7:0] byte_in_sel;

   always_comb begin
      byte_in_sel = byte_ff;
      if (ctrl.clear) begin
         byte_in_sel = 8'h00;
      end else if (ctrl.shift) begin
         byte_in_sel = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_sel;
      end
   end

   assign byte_out = byte_ff;
   // inactive cells lie beyond the pattern and never block a match
   assign hit = !active || (byte_ff == pattern_byte);
endmodule

FILE: design/fsbm_chain.sv
// Row of window cells, newest byte in cell 0, with the match reduction.
module fsbm_chain #(
   parameter int MAX_PATTERN = fsbm_pkg::MAX_PATTERN_DEFAULT,
   parameter int LEN_W       = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsbm_pkg::cell_ctrl_type       ctrl,
   input  logic [7:0]                    byte_in,
   input  logic [MAX_PATTERN-1:0][7:0]   pattern_bytes,
   input  logic [LEN_W-1:0]              active_len,
   output logic                          hit_all
);
   logic [MAX_PATTERN:0][7:0]   link;
   logic [MAX_PATTERN-1:0][7:0] cell_pattern;
   logic [MAX_PATTERN-1:0]      cell_active;
   logic [MAX_PATTERN-1:0]      cell_hit;

   assign link[0] = byte_in;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      // cell i lines up with pattern byte active_len-1-i
      always_comb begin
         cell_pattern[i] = 8'h00;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (active_len == LEN_W'(i + j + 1)) begin
               cell_pattern[i] = pattern_bytes[j];
            end
         end
      end
      assign cell_active[i] = LEN_W'(i) < active_len;

      fsbm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .byte_in      (link[i]),
         .pattern_byte (cell_pattern[i]),
         .active       (cell_active[i]),
         .byte_out     (link[i+1]),
         .hit          (cell_hit[i])
      );
   end

   assign hit_all = &cell_hit;
endmodule

FILE: bench/tb_fixed_string_byte_matcher_core.sv
// Self-checking testbench for the fixed-string byte matcher core.
module tb_fixed_string_byte_matcher_core;

   localparam int MAX_LEN      = fsbm_pkg::MAX_PATTERN_DEFAULT;
   localparam int SETTLE       = 6;        // quiet cycles before a register write
   localparam int RANDOM_ITEMS = 450;
   localparam int MAX_SHOWN    = 10;
   localparam int TIMEOUT_CYC  = 300000;

   typedef enum int {
      ENTRY_ITEM,
      ENTRY_WRITE,
      ENTRY_PAUSE
   } entry_kind_type;

   typedef struct {
      entry_kind_type            kind;
      fsbm_pkg::req_payload_type item;
      fsbm_pkg::csr_payload_type write;
   } stim_entry_type;

   logic clock;
   logic reset;

   fsbm_chan_if #(.PAYLOAD_TYPE(fsbm_pkg::req_payload_type)) req_if ();
   fsbm_chan_if #(.PAYLOAD_TYPE(fsbm_pkg::rsp_payload_type)) rsp_if ();
   fsbm_chan_if #(.PAYLOAD_TYPE(fsbm_pkg::csr_payload_type)) csr_if ();

   fixed_string_byte_matcher_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // Stimulus waiting to go out and reports waiting to come back.
   stim_entry_type            pending_items[$];
   fsbm_pkg::rsp_payload_type awaited_reports[$];

   int   mismatches = 0;
   int   items_taken = 0;
   int   quiet_cycles = 0;
   logic calm;                 // no idling on either side while high

   // Shadow of the matcher: configuration registers and per-file state.
   logic [4:0]  len_reg;
   logic [63:0] pat_lo_reg;
   logic [63:0] pat_hi_reg;
   logic [7:0]  window_q[MAX_LEN];
   int          held_bytes;
   logic [31:0] start_count;
   logic [31:0] line_count;
   logic        seen_match;

   // Pattern as the stimulus side sees it, used to plant occurrences.
   int          stim_len;
   logic [63:0] stim_lo;
   logic [63:0] stim_hi;
   int          items_queued = 0;

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow model
   // ---------------------------------------------------------------------
   function automatic logic [31:0] sat_bump(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic int effective_len(input logic [4:0] code);
      if (code == 5'd0)
         return 1;
      if (int'(code) > MAX_LEN)
         return MAX_LEN;
      return int'(code);
   endfunction

   function automatic logic [7:0] shadow_pattern_byte(input int k);
      if (k < 8)
         return pat_lo_reg[8*k +: 8];
      return pat_hi_reg[8*(k-8) +: 8];
   endfunction

   task automatic clear_file_state();
      for (int i = 0; i < MAX_LEN; i++)
         window_q[i] = 8'h00;
      held_bytes  = 0;
      start_count = 32'd0;
      line_count  = 32'd1;
      seen_match  = 1'b0;
   endtask

   task automatic apply_write(input fsbm_pkg::csr_payload_type w);
      case (w.index)
         fsbm_pkg::REG_PATTERN_LENGTH: len_reg = w.data[4:0];
         fsbm_pkg::REG_PATTERN_LOW:    pat_lo_reg = w.data;
         fsbm_pkg::REG_PATTERN_HIGH:   pat_hi_reg = w.data;
         default: ;
      endcase
   endtask

   // Advance the shadow by one accepted item and queue the report it causes.
   task automatic predict_report(input fsbm_pkg::req_payload_type it);
      fsbm_pkg::rsp_payload_type r;
      int                        len;
      logic                      hit;
      if (it.func == fsbm_pkg::FUNC_EOF) begin
         // a file that never matched ends with a no-match report
         if (!seen_match) begin
            r.report_kind  = fsbm_pkg::KIND_NO_MATCH;
            r.match_offset = 32'd0;
            r.line_number  = line_count;
            awaited_reports.push_back(r);
         end
         clear_file_state();
      end else begin
         for (int i = MAX_LEN - 1; i > 0; i--)
            window_q[i] = window_q[i-1];
         window_q[0] = it.data_byte;
         if (held_bytes < MAX_LEN)
            held_bytes++;
         if (it.data_byte == fsbm_pkg::NEWLINE_BYTE)
            line_count = sat_bump(line_count);
         len = effective_len(len_reg);
         if (held_bytes >= len) begin
            start_count = sat_bump(start_count);
            // pattern byte 0 lines up with the oldest byte of the window
            hit = 1'b1;
            for (int k = 0; k < len; k++)
               if (window_q[len-1-k] != shadow_pattern_byte(k))
                  hit = 1'b0;
            if (hit) begin
               seen_match     = 1'b1;
               r.report_kind  = fsbm_pkg::KIND_MATCH;
               r.match_offset = start_count;
               r.line_number  = line_count;
               awaited_reports.push_back(r);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus queueing helpers
   // ---------------------------------------------------------------------
   task automatic queue_item(input logic func, input logic [7:0] b);
      stim_entry_type e;
      e.kind           = ENTRY_ITEM;
      e.item.func      = func;
      e.item.data_byte = b;
      e.write          = '0;
      pending_items.push_back(e);
      items_queued++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_item(fsbm_pkg::FUNC_DATA, b);
   endtask

   // The byte field of an end-of-file item carries noise; the block ignores it.
   task automatic queue_eof();
      queue_item(fsbm_pkg::FUNC_EOF, 8'($urandom_range(255)));
   endtask

   task automatic queue_write(input logic [1:0] idx, input logic [63:0] data);
      stim_entry_type e;
      e.kind       = ENTRY_WRITE;
      e.item       = '0;
      e.write.index = idx;
      e.write.data  = data;
      pending_items.push_back(e);
   endtask

   // Hold the sender until every awaited report is back.
   task automatic queue_pause();
      stim_entry_type e;
      e.kind  = ENTRY_PAUSE;
      e.item  = '0;
      e.write = '0;
      pending_items.push_back(e);
   endtask

   function automatic logic [7:0] stim_byte(input int k);
      if (k < 8)
         return stim_lo[8*k +: 8];
      return stim_hi[8*(k-8) +: 8];
   endfunction

   // Program all three registers; upper bits of the length word are junk.
   task automatic program_pattern(input logic [4:0] code, input logic [63:0] lo,
                                  input logic [63:0] hi);
      logic [63:0] len_word;
      len_word      = {$urandom, $urandom};
      len_word[4:0] = code;
      queue_write(fsbm_pkg::REG_PATTERN_LENGTH, len_word);
      queue_write(fsbm_pkg::REG_PATTERN_LOW, lo);
      queue_write(fsbm_pkg::REG_PATTERN_HIGH, hi);
      stim_len = effective_len(code);
      stim_lo  = lo;
      stim_hi  = hi;
   endtask

   task automatic queue_pattern();
      for (int k = 0; k < stim_len; k++)
         queue_byte(stim_byte(k));
   endtask

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(9))
         0, 1, 2: return 8'h61;
         3, 4:    return 8'h62;
         5:       return fsbm_pkg::NEWLINE_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic program_random_pattern();
      logic [4:0]  code;
      logic [63:0] lo;
      logic [63:0] hi;
      case ($urandom_range(9))
         0:       code = 5'd0;
         1:       code = 5'($urandom_range(31, MAX_LEN + 1));
         2:       code = 5'(MAX_LEN);
         3, 4:    code = 5'($urandom_range(MAX_LEN, 5));
         default: code = 5'($urandom_range(4, 1));
      endcase
      for (int k = 0; k < 8; k++) begin
         lo[8*k +: 8] = pick_pattern_byte();
         hi[8*k +: 8] = pick_pattern_byte();
      end
      program_pattern(code, lo, hi);
   endtask

   // One file: random bytes with planted occurrences, newlines and stray
   // pattern bytes, sometimes a pattern change or a drain in the middle.
   task automatic queue_random_file();
      int n;
      n = $urandom_range(30);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(19))
            0:       begin
                        queue_pause();
                        if ($urandom_range(1))
                           program_random_pattern();
                     end
            1, 2, 3, 4, 5: queue_pattern();
            6, 7:    queue_byte(fsbm_pkg::NEWLINE_BYTE);
            8, 9, 10, 11, 12, 13, 14:
                     queue_byte(stim_byte($urandom_range(stim_len - 1)));
            default: queue_byte(8'($urandom_range(255)));
         endcase
      end
      queue_eof();
   endtask

   // ---------------------------------------------------------------------
   // Driver: item and register channels
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      logic           req_next;
      logic           csr_next;
      logic           idle_now;
      stim_entry_type head;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         csr_if.valid   <= 1'b0;
         csr_if.payload <= '0;
         calm           <= 1'b0;
         quiet_cycles    = 0;
      end else begin
         req_next = req_if.valid;
         csr_next = csr_if.valid;
         if (req_if.valid && req_if.ready) begin
            predict_report(req_if.payload);
            req_next     = 1'b0;
            items_taken  = items_taken + 1;
            quiet_cycles = 0;
         end else if (quiet_cycles < SETTLE) begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (csr_if.valid && csr_if.ready) begin
            apply_write(csr_if.payload);
            csr_next = 1'b0;
         end
         // the block counts as idle once no report is owed and it has had
         // time to finish an item that causes none
         idle_now = (awaited_reports.size() == 0) && (quiet_cycles >= SETTLE);
         if (!req_next && !csr_next && pending_items.size() != 0) begin
            head = pending_items[0];
            case (head.kind)
               ENTRY_ITEM: begin
                  if (calm || $urandom_range(99) >= 15) begin
                     req_if.payload <= head.item;
                     req_next = 1'b1;
                     void'(pending_items.pop_front());
                  end
               end
               ENTRY_WRITE: begin
                  if (idle_now) begin
                     csr_if.payload <= head.write;
                     csr_next = 1'b1;
                     void'(pending_items.pop_front());
                  end
               end
               ENTRY_PAUSE: begin
                  if (idle_now)
                     void'(pending_items.pop_front());
               end
               default: ;
            endcase
         end
         // one assignment per valid per edge, so a held valid never drops
         req_if.valid <= req_next;
         csr_if.valid <= csr_next;
         calm         <= (items_taken >= 180) && (items_taken < 300);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: report channel, checked against the oldest awaited report
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_proc
      fsbm_pkg::rsp_payload_type got;
      fsbm_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (awaited_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected report: kind %0d offset %0d line %0d",
                           got.report_kind, got.match_offset, got.line_number);
            end else begin
               want = awaited_reports.pop_front();
               if (got.report_kind !== want.report_kind ||
                   got.match_offset !== want.match_offset ||
                   got.line_number !== want.line_number) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN) begin
                     $display("report mismatch: expected kind %0d offset %0d line %0d",
                              want.report_kind, want.match_offset, want.line_number);
                     $display("                 got kind %0d offset %0d line %0d",
                              got.report_kind, got.match_offset, got.line_number);
                  end
               end
            end
         end
         rsp_if.ready <= calm || ($urandom_range(99) >= 15);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready   = 1'b0;
      calm           = 1'b0;
      len_reg        = 5'd1;
      pat_lo_reg     = 64'd0;
      pat_hi_reg     = 64'd0;
      clear_file_state();
      stim_len = 1;
      stim_lo  = 64'd0;
      stim_hi  = 64'd0;

      // Reset pattern is a single zero byte: zero bytes match like any other.
      queue_byte(8'h00);
      queue_byte(fsbm_pkg::NEWLINE_BYTE);
      queue_eof();             // file matched: no report
      queue_eof();             // empty file: no-match on line 1

      // Length code above the maximum acts as the maximum; pattern holds
      // both byte extremes and a newline inside it.
      program_pattern(5'd31, 64'h0AFF_007F_80FE_01FF, 64'h00EF_CDAB_8967_4523);
      queue_pattern();
      queue_eof();

      // Length code zero acts as one.
      program_pattern(5'd0, 64'hA5A5_A5A5_A5A5_A55A, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_byte(8'h5A);
      queue_eof();

      // Random files until the item budget is spent.
      while (items_queued < RANDOM_ITEMS) begin
         if ($urandom_range(3) == 0)
            program_random_pattern();
         queue_random_file();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Drain: stimulus out, reports back, then let the pipe settle.
      while (pending_items.size() != 0 || req_if.valid || csr_if.valid)
         @(posedge clock);
      while (awaited_reports.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (awaited_reports.size() != 0)
         mismatches++;

      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #(8 * TIMEOUT_CYC);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: fixed_string_byte_matcher_core.f
design/fsbm_pkg.sv
design/fsbm_chan_if.sv
design/fsbm_cell.sv
design/fsbm_chain.sv
design/fixed_string_byte_matcher_core.sv
bench/tb_fixed_string_byte_matcher_core.sv
